// File: hdl/mpc_pkg.sv
// shared widths, constants and types for the mandelbrot pixel colouriser
package mpc_pkg;

    localparam int COORD_BITS = 11;
    localparam int FRAC_BITS  = 28;
    localparam int ITER_BITS  = 16;

    localparam int REG_W     = 32;
    localparam int MUL_W     = REG_W + 1;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int Z_W       = REG_W + 2;
    localparam int SQ_W      = PROD_W - FRAC_BITS;
    localparam int ESC_W     = SQ_W + 1;
    localparam int RI_W      = SQ_W + 1;
    localparam int CRD_W     = REG_W + COORD_BITS + 2;
    localparam int SQ2_W     = 2 * ITER_BITS;
    localparam int D_W       = 4 * ITER_BITS;
    localparam int KW        = 13;
    localparam int KL_W      = KW + SQ2_W;
    localparam int NUM_W     = D_W + KW;
    localparam int DEN_W     = D_W + 1;
    localparam int COL_W     = 8;
    localparam int STEP_W    = $clog2(COL_W);
    localparam int DSH_W     = DEN_W + COL_W - 1;
    localparam int CFG_IDX_W = 3;

    localparam logic signed [ESC_W-1:0] ESC_BOUND = ESC_W'(4) << FRAC_BITS;

    localparam logic [KW-1:0] K_RED   = KW'(9 * 255);
    localparam logic [KW-1:0] K_GREEN = KW'(15 * 255);
    localparam logic [KW-1:0] K_BLUE  = KW'(17 * 255);

    localparam logic signed [REG_W-1:0] RST_ORIGIN_REAL = 32'shE000_0000;
    localparam logic signed [REG_W-1:0] RST_ORIGIN_IMAG = 32'shE800_0000;
    localparam logic signed [REG_W-1:0] RST_STEP_REAL   = 32'sd1342177;
    localparam logic signed [REG_W-1:0] RST_STEP_IMAG   = 32'sd1342177;
    localparam logic [ITER_BITS-1:0]    RST_ITER_LIMIT  = ITER_BITS'(100);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORIGIN_REAL,
        CFG_ORIGIN_IMAG,
        CFG_STEP_REAL,
        CFG_STEP_IMAG,
        CFG_ITER_LIMIT
    } t_cfg_idx;

    typedef struct packed {
        logic             done;
        logic [COL_W-1:0] quot;
    } t_div_stat;

endpackage

// File: hdl/mpc_div.sv
// restoring divider giving an eight bit colour quotient, one bit per cycle
module mpc_div import mpc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output t_div_stat        o_stat
);

    logic              r_busy;
    logic [STEP_W-1:0] r_step;
    logic [NUM_W-1:0]  r_rem;
    logic [DSH_W-1:0]  r_dsh;
    logic [COL_W-1:0]  r_q;
    logic [NUM_W-1:0]  dsh_ext;
    logic              ge;

    always_comb begin
        dsh_ext     = {{(NUM_W-DSH_W){1'b0}}, r_dsh};
        ge          = (r_rem >= dsh_ext);
        o_stat.done = r_busy && (r_step == '0);
        o_stat.quot = {r_q[COL_W-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_rem  <= i_num;
            r_dsh  <= {i_den, {(COL_W-1){1'b0}}};
            r_step <= STEP_W'(COL_W - 1);
        end else if (r_busy) begin
            if (ge) begin
                r_rem <= r_rem - dsh_ext;
            end
            r_q   <= {r_q[COL_W-2:0], ge};
            r_dsh <= r_dsh >> 1;
            if (r_step == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_step <= r_step - STEP_W'(1);
            end
        end
    end

endmodule

// File: hdl/mandelbrot_pixel_colorizer.sv
// escape-time iteration and colour mapping for one pixel on a shared multiplier
//
// channel   ports                                        handshake
// request   start, busy, i_pixel_x, i_pixel_y            taken when start && !busy
// result    o_done, o_escape_count, o_red/green/blue     one-cycle strobe
// config    i_cfg_valid, o_cfg_ready, i_cfg_index/data   taken when valid && ready
//
// sequence: the point is mapped, then each update of z runs through UPD, SQR, SQI and TST
// on the one 33x33 multiplier, then the colour (five products, per channel three products,
// a divider start and an eight-step divide); inside points skip the colour
// the result strobe is registered; busy is high from request to strobe
// register writes are held off while a request is in flight or being presented
// synchronous active-low reset returns the sequencer to idle and reloads registers
// the result strobe cannot be held off and is shown for one cycle only
module mandelbrot_pixel_colorizer import mpc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [COORD_BITS-1:0] i_pixel_x,
    input  logic [COORD_BITS-1:0] i_pixel_y,
    output logic                 o_done,
    output logic [ITER_BITS-1:0] o_escape_count,
    output logic [COL_W-1:0]     o_red,
    output logic [COL_W-1:0]     o_green,
    output logic [COL_W-1:0]     o_blue,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [REG_W-1:0]     i_cfg_data
);

    typedef enum logic [4:0] {
        S_IDLE, S_CY, S_CI, S_UPD, S_SQR, S_SQI, S_TST,
        S_CA, S_CB, S_CP, S_CQ, S_CD, S_XM, S_KL, S_KH, S_DST, S_DWT
    } t_state;

    typedef enum logic [1:0] {CH_RED, CH_GREEN, CH_BLUE} t_chan;

    t_state                   r_state;
    t_chan                    r_ch;
    logic                     r_done;
    logic signed [REG_W-1:0]  r_org_re, r_org_im, r_stp_re, r_stp_im;
    logic [ITER_BITS-1:0]     r_lim;
    logic [COORD_BITS-1:0]    r_py;
    logic signed [REG_W-1:0]  r_cr, r_ci;
    logic signed [Z_W-1:0]    r_zr, r_zi;
    logic signed [SQ_W-1:0]   r_sq_r, r_sq_i;
    logic signed [PROD_W-1:0] r_prod;
    logic [ITER_BITS-1:0]     r_count;
    logic [SQ2_W-1:0]         r_ca, r_cb, r_cp, r_xhi;
    logic [D_W-1:0]           r_d;
    logic [KL_W-1:0]          r_nlo;
    logic [COL_W-1:0]         r_red, r_green, r_blue;

    logic signed [MUL_W-1:0]  mul_a, mul_b, zr_op, zi_op;
    logic signed [REG_W-1:0]  coord_org;
    logic signed [CRD_W-1:0]  coord_sum;
    logic signed [REG_W-1:0]  coord_sat;
    logic                     big_r, big_i, escape;
    logic signed [SQ_W-1:0]   sq_new, zr_sum;
    logic signed [ESC_W-1:0]  esc_sum;
    logic signed [RI_W-1:0]   zi_sum;
    logic signed [Z_W-1:0]    upd_zr, upd_zi;
    logic [ITER_BITS-1:0]     a_col, n_count;
    logic [KW-1:0]            k_sel;
    logic [NUM_W-1:0]         div_num;
    logic [DEN_W-1:0]         div_den;
    logic                     div_start;
    t_div_stat                div_stat;

    function automatic logic signed [REG_W-1:0] f_sat(input logic signed [CRD_W-1:0] v);
        if (v[CRD_W-1:REG_W-1] == {(CRD_W-REG_W+1){v[CRD_W-1]}}) begin
            return v[REG_W-1:0];
        end else if (v[CRD_W-1]) begin
            return {1'b1, {(REG_W-1){1'b0}}};
        end else begin
            return {1'b0, {(REG_W-1){1'b1}}};
        end
    endfunction

    function automatic logic signed [MUL_W-1:0] f_clamp(input logic signed [Z_W-1:0] v,
                                                         input logic big);
        logic [REG_W-1:0] t;
        t = big ? {v[Z_W-1], {(REG_W-1){~v[Z_W-1]}}} : v[REG_W-1:0];
        return {{(MUL_W-REG_W){t[REG_W-1]}}, t};
    endfunction

    always_comb begin
        coord_org = (r_state == S_CY) ? r_org_re : r_org_im;
        coord_sum = $signed({{(CRD_W-REG_W){coord_org[REG_W-1]}}, coord_org})
                  + $signed(r_prod[CRD_W-1:0]);
        coord_sat = f_sat(coord_sum);

        big_r = (r_zr[Z_W-1:REG_W-1] != {(Z_W-REG_W+1){r_zr[Z_W-1]}});
        big_i = (r_zi[Z_W-1:REG_W-1] != {(Z_W-REG_W+1){r_zi[Z_W-1]}});
        zr_op = f_clamp(r_zr, big_r);
        zi_op = f_clamp(r_zi, big_i);

        sq_new  = r_prod[PROD_W-1:FRAC_BITS];
        esc_sum = $signed({r_sq_r[SQ_W-1], r_sq_r}) + $signed({sq_new[SQ_W-1], sq_new});
        escape  = big_r || big_i || (esc_sum > ESC_BOUND);

        zr_sum = r_sq_r - r_sq_i + $signed({{(SQ_W-REG_W){r_cr[REG_W-1]}}, r_cr});
        upd_zr = zr_sum[Z_W-1:0];
        zi_sum = $signed(r_prod[PROD_W-1:FRAC_BITS-1])
               + $signed({{(RI_W-REG_W){r_ci[REG_W-1]}}, r_ci});
        upd_zi = zi_sum[Z_W-1:0];

        n_count = r_count + ITER_BITS'(1);
        a_col   = r_lim - r_count;

        case (r_ch)
            CH_RED:   k_sel = K_RED;
            CH_GREEN: k_sel = K_GREEN;
            CH_BLUE:  k_sel = K_BLUE;
            default:  k_sel = K_RED;
        endcase

        div_num   = {r_prod[KL_W-1:0], {SQ2_W{1'b0}}} + {{(NUM_W-KL_W){1'b0}}, r_nlo};
        div_den   = (r_ch == CH_BLUE) ? {r_d, 1'b0} : {1'b0, r_d};
        div_start = (r_state == S_DST);

        // operand selection for the shared multiplier
        case (r_state)
            S_IDLE: begin
                mul_a = $signed({{(MUL_W-COORD_BITS){1'b0}}, i_pixel_x});
                mul_b = $signed({{(MUL_W-REG_W){r_stp_re[REG_W-1]}}, r_stp_re});
            end
            S_CY: begin
                mul_a = $signed({{(MUL_W-COORD_BITS){1'b0}}, r_py});
                mul_b = $signed({{(MUL_W-REG_W){r_stp_im[REG_W-1]}}, r_stp_im});
            end
            S_SQR: begin
                mul_a = zr_op;
                mul_b = zr_op;
            end
            S_SQI: begin
                mul_a = zi_op;
                mul_b = zi_op;
            end
            S_CA: begin
                mul_a = $signed({{(MUL_W-ITER_BITS){1'b0}}, a_col});
                mul_b = $signed({{(MUL_W-ITER_BITS){1'b0}}, a_col});
            end
            S_CB: begin
                mul_a = $signed({{(MUL_W-ITER_BITS){1'b0}}, r_count});
                mul_b = $signed({{(MUL_W-ITER_BITS){1'b0}}, r_count});
            end
            S_CP: begin
                mul_a = $signed({{(MUL_W-ITER_BITS){1'b0}}, a_col});
                mul_b = $signed({{(MUL_W-ITER_BITS){1'b0}}, r_count});
            end
            S_CQ: begin
                mul_a = $signed({{(MUL_W-ITER_BITS){1'b0}}, r_lim});
                mul_b = $signed({{(MUL_W-ITER_BITS){1'b0}}, r_lim});
            end
            S_CD: begin
                mul_a = $signed({{(MUL_W-SQ2_W){1'b0}}, r_prod[SQ2_W-1:0]});
                mul_b = $signed({{(MUL_W-SQ2_W){1'b0}}, r_prod[SQ2_W-1:0]});
            end
            S_XM: begin
                case (r_ch)
                    CH_RED: begin
                        mul_a = $signed({{(MUL_W-SQ2_W){1'b0}}, r_cp});
                        mul_b = $signed({{(MUL_W-SQ2_W){1'b0}}, r_cb});
                    end
                    CH_GREEN: begin
                        mul_a = $signed({{(MUL_W-SQ2_W){1'b0}}, r_ca});
                        mul_b = $signed({{(MUL_W-SQ2_W){1'b0}}, r_cb});
                    end
                    default: begin
                        mul_a = $signed({{(MUL_W-SQ2_W){1'b0}}, r_ca});
                        mul_b = $signed({{(MUL_W-SQ2_W){1'b0}}, r_cp});
                    end
                endcase
            end
            S_KL: begin
                mul_a = $signed({{(MUL_W-KW){1'b0}}, k_sel});
                mul_b = $signed({{(MUL_W-SQ2_W){1'b0}}, r_prod[SQ2_W-1:0]});
            end
            S_KH: begin
                mul_a = $signed({{(MUL_W-KW){1'b0}}, k_sel});
                mul_b = $signed({{(MUL_W-SQ2_W){1'b0}}, r_xhi});
            end
            default: begin
                mul_a = zr_op;
                mul_b = zi_op;
            end
        endcase
    end

    mpc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_stat  (div_stat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_done   <= 1'b0;
            r_org_re <= RST_ORIGIN_REAL;
            r_org_im <= RST_ORIGIN_IMAG;
            r_stp_re <= RST_STEP_REAL;
            r_stp_im <= RST_STEP_IMAG;
            r_lim    <= RST_ITER_LIMIT;
        end else begin
            r_done <= 1'b0;
            r_prod <= mul_a * mul_b;

            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_ORIGIN_REAL: r_org_re <= i_cfg_data;
                    CFG_ORIGIN_IMAG: r_org_im <= i_cfg_data;
                    CFG_STEP_REAL:   r_stp_re <= i_cfg_data;
                    CFG_STEP_IMAG:   r_stp_im <= i_cfg_data;
                    CFG_ITER_LIMIT:  r_lim    <= i_cfg_data[ITER_BITS-1:0];
                    default: ;
                endcase
            end

            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_py    <= i_pixel_y;
                        r_zr    <= '0;
                        r_zi    <= '0;
                        r_sq_r  <= '0;
                        r_sq_i  <= '0;
                        r_count <= '0;
                        r_red   <= '0;
                        r_green <= '0;
                        r_blue  <= '0;
                        r_ch    <= CH_RED;
                        r_state <= S_CY;
                    end
                end
                S_CY: begin
                    r_cr    <= coord_sat;
                    r_state <= S_CI;
                end
                S_CI: begin
                    r_ci <= coord_sat;
                    if (r_lim == '0) begin
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_UPD;
                    end
                end
                S_UPD: begin
                    r_zr    <= upd_zr;
                    r_zi    <= upd_zi;
                    r_state <= S_SQR;
                end
                S_SQR: begin
                    r_state <= S_SQI;
                end
                S_SQI: begin
                    r_sq_r  <= sq_new;
                    r_state <= S_TST;
                end
                S_TST: begin
                    r_sq_i <= sq_new;
                    if (escape) begin
                        r_state <= S_CA;
                    end else begin
                        r_count <= n_count;
                        if (n_count == r_lim) begin
                            r_done  <= 1'b1;
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_UPD;
                        end
                    end
                end
                S_CA: begin
                    r_state <= S_CB;
                end
                S_CB: begin
                    r_ca    <= r_prod[SQ2_W-1:0];
                    r_state <= S_CP;
                end
                S_CP: begin
                    r_cb    <= r_prod[SQ2_W-1:0];
                    r_state <= S_CQ;
                end
                S_CQ: begin
                    r_cp    <= r_prod[SQ2_W-1:0];
                    r_state <= S_CD;
                end
                S_CD: begin
                    r_state <= S_XM;
                end
                S_XM: begin
                    if (r_ch == CH_RED) begin
                        r_d <= r_prod[D_W-1:0];
                    end
                    r_state <= S_KL;
                end
                S_KL: begin
                    r_xhi   <= r_prod[D_W-1:SQ2_W];
                    r_state <= S_KH;
                end
                S_KH: begin
                    r_nlo   <= r_prod[KL_W-1:0];
                    r_state <= S_DST;
                end
                S_DST: begin
                    r_state <= S_DWT;
                end
                S_DWT: begin
                    if (div_stat.done) begin
                        case (r_ch)
                            CH_RED: begin
                                r_red   <= div_stat.quot;
                                r_ch    <= CH_GREEN;
                                r_state <= S_XM;
                            end
                            CH_GREEN: begin
                                r_green <= div_stat.quot;
                                r_ch    <= CH_BLUE;
                                r_state <= S_XM;
                            end
                            default: begin
                                r_blue  <= div_stat.quot;
                                r_done  <= 1'b1;
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy           = (r_state != S_IDLE);
    assign o_done         = r_done;
    assign o_escape_count = r_count;
    assign o_red          = r_red;
    assign o_green        = r_green;
    assign o_blue         = r_blue;
    assign o_cfg_ready    = !busy && !start;

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("request taken but sequencer not busy");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while sequencer still busy");

    a_div_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_stat.done |-> (r_state == S_DWT))
        else $error("divider finished while sequencer not waiting");

endmodule
